>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

>>> src/clp_pkg.sv
// ----------------------------------------------------------------------------
// Command list packer package
// Types, constants and the parameter count table shared by the packer files.
// ----------------------------------------------------------------------------
package clp_pkg;

	// Largest list the target buffer may hold, in words.
	localparam int MaxListWords = 4096;

	// Field widths.
	localparam int PosW   = 16;
	localparam int CapW   = 13;
	localparam int DataW  = 32;
	localparam int CodeW  = 8;
	localparam int SlotW  = 3;
	localparam int DueW   = 5;

	// Reset value of the capacity register.
	localparam logic [CapW-1:0] CapReset = 13'd4096;

	// Highest write position; the position saturates here.
	localparam logic [PosW-1:0] PosMax = 16'hFFFF;

	// Number of header slots, one byte each.
	localparam logic [SlotW-1:0] SlotsFull = 3'd4;

	// Depth of the result queue, in beats.
	localparam int QueueDepth = 4;

	// Request modes.
	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_APPEND = 2'd2,
		CMD_FINISH = 2'd3
	} clp_cmd_t;

	// One result beat.
	typedef struct packed {
		logic             write_valid;
		logic [PosW-1:0]  word_index;
		logic [DataW-1:0] word_data;
		logic [PosW-1:0]  list_length;
		logic             last;
	} clp_result_t;

	// Beats produced by one accepted request.
	typedef struct packed {
		logic [1:0]  count;
		clp_result_t first;
		clp_result_t second;
	} clp_push_t;

	// Parameter words that follow each geometry command code.
	function automatic logic [DueW-1:0] param_count(input logic [CodeW-1:0] code);
		logic [DueW-1:0] cnt;
		cnt = '0;
		case (code) inside
			8'd16, 8'd18, 8'd19, 8'd20:          cnt = 5'd1;
			8'd22, 8'd24:                        cnt = 5'd16;
			8'd23, 8'd25:                        cnt = 5'd12;
			8'd26:                               cnt = 5'd9;
			8'd27, 8'd28:                        cnt = 5'd3;
			8'd35:                               cnt = 5'd2;
			[8'd32:8'd34], [8'd36:8'd43]:        cnt = 5'd1;
			[8'd48:8'd51], 8'd64:                cnt = 5'd1;
			default:                             cnt = 5'd0;
		endcase
		return cnt;
	endfunction

endpackage

>>> src/clp_packer_core.sv
// ----------------------------------------------------------------------------
// Packer core
// Holds the list state and the capacity register and turns one request into
// zero, one or two result beats combinationally.
// ----------------------------------------------------------------------------
module clp_packer_core import clp_pkg::*; #(
	parameter int MAX_LIST_WORDS = MaxListWords
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CapW-1:0]  cfg_wdata,
	input  logic             accept,
	input  logic [1:0]       cmd,
	input  logic [CodeW-1:0] command_code,
	input  logic [DataW-1:0] data_word,
	output clp_push_t        push
);

	localparam logic [PosW-1:0] MaxWords = PosW'(MAX_LIST_WORDS);

	logic [CapW-1:0]  capacity_q;
	logic [PosW-1:0]  write_pos_q, write_pos_d;
	logic [PosW-1:0]  header_pos_q, header_pos_d;
	logic [DataW-1:0] header_value_q, header_value_d;
	logic [SlotW-1:0] slot_count_q, slot_count_d;
	logic [DueW-1:0]  params_due_q, params_due_d;

	logic [PosW-1:0]  cap;
	logic [PosW-1:0]  used;
	logic [PosW-1:0]  pos_inc;
	logic [PosW-1:0]  pos_mid;
	logic [PosW-1:0]  pos_mid_inc;
	logic [DueW-1:0]  cnt;
	logic             open_header;
	clp_cmd_t         mode;

	// Effective capacity is the register clipped to the buffer size.
	always_comb begin
		cap  = ({3'b0, capacity_q} > MaxWords) ? MaxWords : {3'b0, capacity_q};
		used = (write_pos_q <= cap) ? write_pos_q : cap;
	end

	// Saturating position steps: one for a header, one for a parameter.
	always_comb begin
		cnt         = param_count(command_code);
		open_header = slot_count_q[2] || (cnt == '0);
		pos_inc     = (write_pos_q < PosMax) ? write_pos_q + 16'd1 : write_pos_q;
		pos_mid     = (params_due_q == '0 && open_header) ? pos_inc : write_pos_q;
		pos_mid_inc = (pos_mid < PosMax) ? pos_mid + 16'd1 : pos_mid;
	end

	// Decode the request into next state and result beats.
	always_comb begin
		mode           = clp_cmd_t'(cmd);
		write_pos_d    = write_pos_q;
		header_pos_d   = header_pos_q;
		header_value_d = header_value_q;
		slot_count_d   = slot_count_q;
		params_due_d   = params_due_q;
		push           = '0;
		unique case (mode)
			CMD_START: begin
				write_pos_d  = 16'd1;
				slot_count_d = SlotsFull;
				params_due_d = '0;
			end
			CMD_FINISH: begin
				push.count             = 2'd1;
				push.first.write_valid = (cap != '0);
				push.first.word_index  = '0;
				push.first.word_data   = (cap != '0) ? {16'b0, used - 16'd1} : '0;
				push.first.list_length = write_pos_q;
				push.first.last        = 1'b1;
			end
			CMD_APPEND: begin
				push.count             = 2'd1;
				push.first.write_valid = (write_pos_q < cap);
				push.first.word_index  = write_pos_q;
				push.first.word_data   = data_word;
				push.first.last        = 1'b1;
				write_pos_d            = pos_inc;
				slot_count_d           = SlotsFull;
				params_due_d           = '0;
			end
			CMD_WRITE: begin
				if (params_due_q == '0) begin
					// Open a new header or merge the code into the open one.
					if (open_header) begin
						header_pos_d   = write_pos_q;
						header_value_d = {24'b0, command_code};
						slot_count_d   = 3'd1;
					end else begin
						header_value_d = header_value_q |
							({24'b0, command_code} << {slot_count_q[1:0], 3'b0});
						slot_count_d   = slot_count_q + 3'd1;
					end
					push.first.write_valid = (header_pos_d < cap);
					push.first.word_index  = header_pos_d;
					push.first.word_data   = header_value_d;
					if (cnt == '0) begin
						push.count      = 2'd1;
						push.first.last = 1'b1;
						write_pos_d     = pos_mid;
					end else begin
						// First parameter follows the header in the same request.
						push.count              = 2'd2;
						push.second.write_valid = (pos_mid < cap);
						push.second.word_index  = pos_mid;
						push.second.word_data   = data_word;
						push.second.last        = 1'b1;
						write_pos_d             = pos_mid_inc;
						params_due_d            = cnt - 5'd1;
					end
				end else begin
					push.count             = 2'd1;
					push.first.write_valid = (write_pos_q < cap);
					push.first.word_index  = write_pos_q;
					push.first.word_data   = data_word;
					push.first.last        = 1'b1;
					write_pos_d            = pos_inc;
					params_due_d           = params_due_q - 5'd1;
				end
			end
			default: begin
				push = '0;
			end
		endcase
		if (!accept) begin
			push.count = 2'd0;
		end
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CapReset;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// List state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q    <= 16'd1;
			header_pos_q   <= '0;
			header_value_q <= '0;
			slot_count_q   <= SlotsFull;
			params_due_q   <= '0;
		end else if (accept) begin
			write_pos_q    <= write_pos_d;
			header_pos_q   <= header_pos_d;
			header_value_q <= header_value_d;
			slot_count_q   <= slot_count_d;
			params_due_q   <= params_due_d;
		end
	end

endmodule

>>> src/clp_result_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two beats a cycle and hands one beat
// a cycle to the output channel while rsp_stall is low.
// ----------------------------------------------------------------------------
module clp_result_queue import clp_pkg::*; #(
	parameter int DEPTH = QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  clp_push_t   push,
	output logic        full,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output clp_result_t rsp
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	clp_result_t         entry_q [DEPTH];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                pop;
	logic [PtrW-1:0]     wr_ptr_next;

	// Room for a two-beat request is required before accepting.
	assign full      = (count_q > CntW'(DEPTH - 2));
	assign rsp_valid = (count_q != '0);
	assign rsp       = entry_q[rd_ptr_q];
	assign pop       = rsp_valid && !rsp_stall;
	assign wr_ptr_next = wr_ptr_q + PtrW'(1);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_next] <= push.second;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			count_q <= count_q + CntW'(push.count) - CntW'(pop);
		end
	end

endmodule

>>> src/command_list_packer.sv
// ----------------------------------------------------------------------------
// Command list packer
// Packs geometry command writes into a display list as indexed word writes.
// ----------------------------------------------------------------------------
// The block accepts one request per cycle while req_stall is low. A request
// that opens a command with parameters produces two beats (header word and
// first parameter); all other requests produce one beat, and a start request
// produces none. Beats leave through a four-entry result queue, one per cycle
// while rsp_stall is low, and a request is stalled while fewer than two
// entries are free, so a stream of two-beat requests is paced by the output
// port. Each beat is registered in the queue and leaves it in order.
module command_list_packer import clp_pkg::*; #(
	parameter int MAX_LIST_WORDS = MaxListWords
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CapW-1:0]  cfg_wdata,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [1:0]       cmd,
	input  logic [CodeW-1:0] command_code,
	input  logic [DataW-1:0] data_word,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic             write_valid,
	output logic [PosW-1:0]  word_index,
	output logic [DataW-1:0] word_data,
	output logic [PosW-1:0]  list_length,
	output logic             last
);

	logic        accept;
	clp_push_t   push;
	clp_result_t rsp;

	assign accept = req_valid && !req_stall;

	// List state and per-request decode.
	clp_packer_core #(
		.MAX_LIST_WORDS(MAX_LIST_WORDS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.cmd          (cmd),
		.command_code (command_code),
		.data_word    (data_word),
		.push         (push)
	);

	// Output buffering.
	clp_result_queue #(
		.DEPTH(QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	assign write_valid = rsp.write_valid;
	assign word_index  = rsp.word_index;
	assign word_data   = rsp.word_data;
	assign list_length = rsp.list_length;
	assign last        = rsp.last;

endmodule

>>> src/clp_checker.sv
// ----------------------------------------------------------------------------
// Packer port checker
// Watches the ports of the command list packer for timing and beat rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clp_checker import clp_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_stall,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input logic [PosW-1:0]  word_index,
	input logic [DataW-1:0] word_data,
	input logic [PosW-1:0]  list_length,
	input logic             last
);

	// A stalled output beat holds its data.
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(word_data) && $stable(word_index))

	// The second beat of a pair is already queued behind the first.
	`ASSERT_NEXT(a_pair_follows, clk, arst_n, rsp_valid && !last, rsp_valid)

	// Only the length word lands at index zero, and it closes its request.
	`ASSERT_IMPLIES(a_index_zero, clk, arst_n, rsp_valid && word_index == '0, last && list_length != '0)

	// An empty result queue never holds off requests.
	`ASSERT_IMPLIES(a_empty_accepts, clk, arst_n, !rsp_valid, !req_stall)

endmodule

bind command_list_packer clp_checker u_clp_checker (.*);

>>> dv/command_list_packer_tb.sv
// ----------------------------------------------------------------------------
// Command list packer testbench
// Drives start, command, append and finish requests into the packer, predicts
// every indexed word write from its own model of the list state, and compares
// each result beat field by field while both handshakes idle and stall.
// ----------------------------------------------------------------------------
module command_list_packer_tb;
	import clp_pkg::*;

	localparam int CycleLimit  = 2_000_000;
	localparam int HoldCycles  = 200;
	localparam int MaxReports  = 40;
	localparam int RandomItems = 1670;

	// Clock, reset and block ports; the driven inputs are at known values from time zero.
	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             cfg_we       = 1'b0;
	logic [CapW-1:0]  cfg_wdata    = '0;
	logic             req_valid    = 1'b0;
	logic             req_stall;
	logic [1:0]       cmd          = CMD_START;
	logic [CodeW-1:0] command_code = '0;
	logic [DataW-1:0] data_word    = '0;
	logic             rsp_valid;
	logic             rsp_stall    = 1'b0;
	logic             write_valid;
	logic [PosW-1:0]  word_index;
	logic [DataW-1:0] word_data;
	logic [PosW-1:0]  list_length;
	logic             last;

	// Predicted list state and the capacity register.
	logic [CapW-1:0]  cap_reg     = CapReset;
	logic [PosW-1:0]  pos_next    = 16'd1;
	logic [PosW-1:0]  hdr_pos     = '0;
	logic [DataW-1:0] hdr_word    = '0;
	logic [SlotW-1:0] hdr_slots   = SlotsFull;
	logic [DueW-1:0]  params_left = '0;

	// Word writes predicted but not yet seen on the output.
	clp_result_t pending_writes[$];

	// Run bookkeeping.
	int  errors          = 0;
	int  requests_sent   = 0;
	int  beats_seen      = 0;
	int  lists_finished  = 0;
	int  cap_writes      = 0;
	int  held_cycles     = 0;
	int  cycle_count     = 0;
	bit  idle_on         = 1'b1;
	bit  hold_request    = 1'b0;

	command_list_packer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.command_code (command_code),
		.data_word    (data_word),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.write_valid  (write_valid),
		.word_index   (word_index),
		.word_data    (word_data),
		.list_length  (list_length),
		.last         (last)
	);

	// Free-running clock with a period of 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Parameter words that follow each command code; unknown codes take none.
	function automatic int params_after(input logic [CodeW-1:0] code);
		case (code)
			8'd22, 8'd24: return 16;
			8'd23, 8'd25: return 12;
			8'd26:        return 9;
			8'd27, 8'd28: return 3;
			8'd35:        return 2;
			8'd16, 8'd18, 8'd19, 8'd20, 8'd32, 8'd33, 8'd34, 8'd36, 8'd37, 8'd38,
			8'd39, 8'd40, 8'd41, 8'd42, 8'd43, 8'd48, 8'd49, 8'd50, 8'd51,
			8'd64:        return 1;
			default:      return 0;
		endcase
	endfunction

	// Capacity in effect, clipped to the largest list the buffer holds.
	function automatic logic [PosW-1:0] usable_words();
		return (cap_reg > MaxListWords) ? PosW'(MaxListWords) : PosW'(cap_reg);
	endfunction

	function automatic void step_pos();
		if (pos_next != PosMax)
			pos_next++;
	endfunction

	function automatic void push_write(input logic [PosW-1:0] idx, input logic [DataW-1:0] data,
			input logic [PosW-1:0] len, input logic fin);
		clp_result_t beat;
		beat.write_valid = (idx < usable_words());
		beat.word_index  = idx;
		beat.word_data   = data;
		beat.list_length = len;
		beat.last        = fin;
		pending_writes.push_back(beat);
	endfunction

	// Advance the list state by one accepted request and queue its writes.
	function automatic void pack_request(input clp_cmd_t op, input logic [CodeW-1:0] code,
			input logic [DataW-1:0] data);
		logic [PosW-1:0] cap;
		logic [PosW-1:0] used;
		int              cnt;
		bit              header_only;
		cap = usable_words();
		header_only = 1'b0;
		case (op)
			CMD_START: begin
				pos_next    = 16'd1;
				hdr_slots   = SlotsFull;
				params_left = '0;
			end
			CMD_FINISH: begin
				// The length word counts only what fits in the buffer.
				used = (pos_next <= cap) ? pos_next : cap;
				push_write('0, (cap != 0) ? DataW'(used - 16'd1) : '0, pos_next, 1'b1);
			end
			CMD_APPEND: begin
				push_write(pos_next, data, '0, 1'b1);
				step_pos();
				hdr_slots   = SlotsFull;
				params_left = '0;
			end
			default: begin
				if (params_left == 0) begin
					cnt = params_after(code);
					// A full header or a bare command opens a fresh header word.
					if (hdr_slots >= SlotsFull || cnt == 0) begin
						hdr_pos   = pos_next;
						step_pos();
						hdr_word  = DataW'(code);
						hdr_slots = 3'd1;
					end else begin
						hdr_word  = hdr_word | (DataW'(code) << (8 * hdr_slots[1:0]));
						hdr_slots = hdr_slots + 3'd1;
					end
					header_only = (cnt == 0);
					push_write(hdr_pos, hdr_word, '0, header_only);
					params_left = DueW'(cnt);
				end
				if (!header_only) begin
					push_write(pos_next, data, '0, 1'b1);
					step_pos();
					params_left = params_left - 5'd1;
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MaxReports)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
	endtask

	// Mostly back to back, some short pauses, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one request and hold it until the block takes it.
	task automatic send_request(input clp_cmd_t op, input logic [CodeW-1:0] code,
			input logic [DataW-1:0] data);
		int gap;
		req_valid    <= 1'b1;
		cmd          <= op;
		command_code <= code;
		data_word    <= data;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pack_request(op, code, data);
		requests_sent++;
		if (op == CMD_FINISH)
			lists_finished++;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Let every predicted write arrive, then let silent requests settle as well.
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CapW-1:0] words);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= words;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cap_reg    = words;
		cap_writes++;
	endtask

	// Receiver pacing: random stall spans, no stalls while idling is off, or one long hold when requested.
	initial begin : rsp_pacer
		bit stalling;
		int span_left;
		stalling  = 1'b0;
		span_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (!idle_on) begin
				rsp_stall <= 1'b0;
			end else begin
				if (span_left == 0) begin
					stalling  = !stalling;
					span_left = stalling ? pick_gap() : $urandom_range(1, 25);
				end
				if (span_left > 0)
					span_left--;
				rsp_stall <= stalling && (span_left >= 0);
			end
		end
	end

	// Compare each delivered beat with the oldest predicted write.
	always @(posedge clk) begin : beat_checker
		clp_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			beats_seen++;
			if (pending_writes.size() == 0) begin
				report_mismatch($sformatf("beat with nothing expected, index %0h data %0h",
					word_index, word_data));
			end else begin
				want = pending_writes.pop_front();
				if (write_valid !== want.write_valid)
					report_mismatch($sformatf("write_valid %0b, expected %0b at index %0h",
						write_valid, want.write_valid, want.word_index));
				if (word_index !== want.word_index)
					report_mismatch($sformatf("word_index %0h, expected %0h",
						word_index, want.word_index));
				if (word_data !== want.word_data)
					report_mismatch($sformatf("word_data %0h, expected %0h at index %0h",
						word_data, want.word_data, want.word_index));
				if (list_length !== want.list_length)
					report_mismatch($sformatf("list_length %0h, expected %0h",
						list_length, want.list_length));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b at index %0h",
						last, want.last, want.word_index));
			end
		end
	end

	// Cycle count, input back-pressure count and the run time limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (req_valid && req_stall)
			held_cycles <= held_cycles + 1;
		if (cycle_count >= CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Finishing before any request reports the empty list; then a bare header.
	task automatic test_reset_state();
		send_request(CMD_FINISH, 8'd0, 32'd0);
		send_request(CMD_WRITE, 8'd0, 32'd0);
		send_request(CMD_FINISH, 8'd0, 32'd0);
	endtask

	// Header sharing, parameter runs, bare and unknown codes, raw appends.
	task automatic test_command_packing();
		send_request(CMD_START, 8'd0, 32'd0);
		send_request(CMD_WRITE, 8'd16, 32'h0000_0000);
		send_request(CMD_WRITE, 8'd35, 32'hFFFF_FFFF);
		send_request(CMD_WRITE, 8'hFF, 32'hA5A5_5A5A);
		send_request(CMD_WRITE, 8'd27, 32'h0000_0001);
		send_request(CMD_WRITE, 8'h00, 32'h8000_0000);
		send_request(CMD_WRITE, 8'hAA, 32'h5555_AAAA);
		send_request(CMD_WRITE, 8'd64, 32'h1234_5678);
		send_request(CMD_WRITE, 8'd16, 32'hDEAD_BEEF);
		send_request(CMD_WRITE, 8'd0, 32'hFFFF_FFFF);
		send_request(CMD_WRITE, 8'd21, 32'h0F0F_0F0F);
		send_request(CMD_WRITE, 8'd65, 32'h0000_0000);
		send_request(CMD_WRITE, 8'd66, 32'h0000_0000);
		send_request(CMD_WRITE, 8'd255, 32'hFFFF_FFFF);
		send_request(CMD_APPEND, 8'd0, 32'hFFFF_FFFF);
		send_request(CMD_WRITE, 8'd18, 32'h0000_0000);
		send_request(CMD_APPEND, 8'hFF, 32'h0000_0000);
		send_request(CMD_FINISH, 8'd0, 32'd0);
	endtask

	// Zero, tiny and oversize capacities, including a change between finishes.
	task automatic test_capacity_limits();
		set_capacity(13'd0);
		send_request(CMD_START, 8'd0, 32'd0);
		send_request(CMD_WRITE, 8'd16, 32'hCAFE_F00D);
		send_request(CMD_FINISH, 8'd0, 32'd0);
		set_capacity(13'd1);
		send_request(CMD_START, 8'd0, 32'd0);
		send_request(CMD_APPEND, 8'd0, 32'h0000_0001);
		send_request(CMD_FINISH, 8'd0, 32'd0);
		set_capacity(13'd3);
		send_request(CMD_START, 8'd0, 32'd0);
		repeat (4) send_request(CMD_APPEND, 8'd0, $urandom());
		send_request(CMD_FINISH, 8'd0, 32'd0);
		set_capacity(13'h1FFF);
		send_request(CMD_FINISH, 8'd0, 32'd0);
		set_capacity(CapReset);
		send_request(CMD_FINISH, 8'd0, 32'd0);
	endtask

	// Receiver holds off for a long stretch while two-beat commands keep coming.
	task automatic test_output_hold_off();
		wait_idle();
		idle_on = 1'b0;
		hold_request = 1'b1;
		send_request(CMD_START, 8'd0, 32'd0);
		for (int i = 0; i < 40; i++)
			send_request(CMD_WRITE, (i % 2 == 0) ? 8'd16 : 8'd48, $urandom());
		send_request(CMD_FINISH, 8'd0, 32'd0);
		wait_idle();
		idle_on = 1'b1;
	endtask

	// Mostly table codes, with a share of codes from the whole byte range.
	function automatic logic [CodeW-1:0] pick_code();
		if ($urandom_range(0, 3) != 0)
			return CodeW'($urandom_range(0, 65));
		return CodeW'($urandom_range(0, 255));
	endfunction

	// Well-formed lists with random content, plus broken runs and raw noise.
	task automatic random_lists(input int quota);
		int               target;
		int               n_cmds;
		int               n_params;
		logic [CodeW-1:0] code;
		target = requests_sent + quota;
		while (requests_sent < target) begin
			if ($urandom_range(0, 99) < 80) begin
				send_request(CMD_START, CodeW'($urandom()), $urandom());
				n_cmds = $urandom_range(1, 10);
				for (int c = 0; c < n_cmds; c++) begin
					if ($urandom_range(0, 9) == 0)
						send_request(CMD_APPEND, CodeW'($urandom()), $urandom());
					code = pick_code();
					n_params = params_after(code);
					n_params = (n_params > 0) ? n_params - 1 : 0;
					// Occasionally cut a parameter run short.
					if (n_params > 0 && $urandom_range(0, 19) == 0)
						n_params = $urandom_range(0, n_params - 1);
					send_request(CMD_WRITE, code, $urandom());
					for (int p = 0; p < n_params; p++)
						send_request(CMD_WRITE, CodeW'($urandom()), $urandom());
				end
				if ($urandom_range(0, 9) != 0)
					send_request(CMD_FINISH, CodeW'($urandom()), $urandom());
			end else begin
				repeat ($urandom_range(1, 6))
					send_request(clp_cmd_t'($urandom_range(0, 3)), CodeW'($urandom()),
						$urandom());
			end
		end
	endtask

	// Random traffic at a small, a mid-range and an oversize capacity.
	task automatic test_random_lists();
		set_capacity(CapW'($urandom_range(0, 24)));
		random_lists(RandomItems / 3);
		set_capacity(CapW'($urandom_range(25, 4096)));
		idle_on = 1'b0;
		random_lists(RandomItems / 3);
		set_capacity(CapW'($urandom_range(4097, 8191)));
		idle_on = 1'b1;
		random_lists(RandomItems - 2 * (RandomItems / 3));
	endtask

	// Test sequence, end of run and verdict.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_command_packing();
		test_capacity_limits();
		test_output_hold_off();
		test_random_lists();
		wait_idle();
		repeat (10) @(posedge clk);
		if (pending_writes.size() != 0)
			report_mismatch($sformatf("%0d expected writes never arrived",
				pending_writes.size()));
		$display("Run covered %0d requests, %0d finished lists and %0d checked write beats.",
			requests_sent, lists_finished, beats_seen);
		$display("Capacity was rewritten %0d times; the input was held back on %0d cycles.",
			cap_writes, held_cycles);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/clp_pkg.sv
src/clp_packer_core.sv
src/clp_result_queue.sv
src/command_list_packer.sv
src/clp_checker.sv
dv/command_list_packer_tb.sv
